@@ sv/hcpg_pkg.sv @@
// hcpg_pkg: shared types, constants and the microcode table of the hermite curve point generator
// no dependencies; used by the interfaces, the divider and the top level

package hcpg_pkg;

  localparam int POINT_COUNT_W = 7;
  localparam int OUT_W         = 20;
  localparam int NUM_REGS      = 8;
  localparam int CFG_IDX_W     = 3;

  // curve parameter u in unsigned q1.16
  localparam int U_FRAC = 16;
  localparam int U_W    = U_FRAC + 1;
  localparam logic [U_W-1:0] U_ONE = {1'b1, {U_FRAC{1'b0}}};

  // split point of the exact product and width of the folded low part
  localparam int SPLIT_W = 24;
  localparam int T_W     = 16;

  localparam int OUT_MAX = 524287;
  localparam int OUT_MIN = -524288;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_P0_X,
    REG_P0_Y,
    REG_P1_X,
    REG_P1_Y,
    REG_T0_X,
    REG_T0_Y,
    REG_T1_X,
    REG_T1_Y
  } reg_idx_t;

  localparam int REG_RESET [NUM_REGS] = '{-5, 0, 5, 0, 5, -1, 5, 1};

  typedef enum logic [2:0] {
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_H1,
    OP_H2,
    OP_LO,
    OP_HI,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    J_NEXT,
    J_DIV_LOOP,
    J_EMIT
  } jmp_t;

  typedef enum logic {
    SEL_X,
    SEL_Y
  } sel_t;

  localparam int PC_W = 4;

  typedef struct packed {
    op_t             op;
    sel_t            sel;
    jmp_t            jmp;
    logic [PC_W-1:0] tgt;
  } ctrl_word_t;

  typedef struct packed {
    logic init;
    logic step;
  } div_ctl_t;

  localparam logic [PC_W-1:0] S_DIV_INIT = 4'd0;
  localparam logic [PC_W-1:0] S_DIV_STEP = 4'd1;
  localparam logic [PC_W-1:0] S_H1_X     = 4'd2;
  localparam logic [PC_W-1:0] S_H2_X     = 4'd3;
  localparam logic [PC_W-1:0] S_LO_X     = 4'd4;
  localparam logic [PC_W-1:0] S_HI_X     = 4'd5;
  localparam logic [PC_W-1:0] S_H1_Y     = 4'd6;
  localparam logic [PC_W-1:0] S_H2_Y     = 4'd7;
  localparam logic [PC_W-1:0] S_LO_Y     = 4'd8;
  localparam logic [PC_W-1:0] S_HI_Y     = 4'd9;
  localparam logic [PC_W-1:0] S_EMIT     = 4'd10;

  // per point: divide, horner in x, horner in y, hand over
  function automatic ctrl_word_t ucode_rd(input logic [PC_W-1:0] pc);
    ctrl_word_t w;
    w = '{op: OP_DIV_INIT, sel: SEL_X, jmp: J_NEXT, tgt: S_DIV_INIT};
    case (pc)
      S_DIV_INIT: w = '{op: OP_DIV_INIT, sel: SEL_X, jmp: J_NEXT,     tgt: S_DIV_INIT};
      S_DIV_STEP: w = '{op: OP_DIV_STEP, sel: SEL_X, jmp: J_DIV_LOOP, tgt: S_DIV_STEP};
      S_H1_X:     w = '{op: OP_H1,       sel: SEL_X, jmp: J_NEXT,     tgt: S_DIV_INIT};
      S_H2_X:     w = '{op: OP_H2,       sel: SEL_X, jmp: J_NEXT,     tgt: S_DIV_INIT};
      S_LO_X:     w = '{op: OP_LO,       sel: SEL_X, jmp: J_NEXT,     tgt: S_DIV_INIT};
      S_HI_X:     w = '{op: OP_HI,       sel: SEL_X, jmp: J_NEXT,     tgt: S_DIV_INIT};
      S_H1_Y:     w = '{op: OP_H1,       sel: SEL_Y, jmp: J_NEXT,     tgt: S_DIV_INIT};
      S_H2_Y:     w = '{op: OP_H2,       sel: SEL_Y, jmp: J_NEXT,     tgt: S_DIV_INIT};
      S_LO_Y:     w = '{op: OP_LO,       sel: SEL_Y, jmp: J_NEXT,     tgt: S_DIV_INIT};
      S_HI_Y:     w = '{op: OP_HI,       sel: SEL_Y, jmp: J_NEXT,     tgt: S_DIV_INIT};
      S_EMIT:     w = '{op: OP_EMIT,     sel: SEL_X, jmp: J_EMIT,     tgt: S_DIV_INIT};
      default:    w = '{op: OP_DIV_INIT, sel: SEL_X, jmp: J_NEXT,     tgt: S_DIV_INIT};
    endcase
    return w;
  endfunction

endpackage

@@ sv/hcpg_in_if.sv @@
// hcpg_in_if: request channel of the hermite curve point generator
// depends on hcpg_pkg for the payload width

interface hcpg_in_if;
  logic                                valid;
  logic                                ready;
  logic [hcpg_pkg::POINT_COUNT_W-1:0] point_count;

  modport source (output valid, output point_count, input ready);
  modport sink   (input valid, input point_count, output ready);
endinterface

@@ sv/hcpg_out_if.sv @@
// hcpg_out_if: curve point channel of the hermite curve point generator
// depends on hcpg_pkg for the payload widths

interface hcpg_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [hcpg_pkg::OUT_W-1:0] x_pos;
  logic signed [hcpg_pkg::OUT_W-1:0] y_pos;
  logic                               is_last;

  modport source (output valid, output x_pos, output y_pos, output is_last, input ready);
  modport sink   (input valid, input x_pos, input y_pos, input is_last, output ready);
endinterface

@@ sv/hcpg_divider.sv @@
// hcpg_divider: restoring divider, one quotient bit per cycle while step is asserted, forms (idx << 16) / divisor
// depends on hcpg_pkg for div_ctl_t and the width of u

module hcpg_divider #(
  parameter int IW = 6
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  hcpg_pkg::div_ctl_t         ctl,
  input  logic [IW-1:0]              dividend_idx,
  input  logic [IW-1:0]              divisor,
  output logic [hcpg_pkg::U_W-1:0]   quot,
  output logic                       done
);

  localparam int NW   = IW + hcpg_pkg::U_FRAC;
  localparam int CNTW = $clog2(NW);

  logic [NW-1:0]   num_r;
  logic [NW-1:0]   q_r;
  logic [IW-1:0]   rem_r;
  logic [CNTW-1:0] cnt_r;
  logic [CNTW-1:0] cnt_nxt;
  logic [IW:0]     trial;
  logic            fits;

  assign trial   = {rem_r, num_r[NW-1]};
  assign fits    = trial >= {1'b0, divisor};
  assign done    = cnt_r == CNTW'(NW - 1);
  assign cnt_nxt = done ? '0 : cnt_r + CNTW'(1);
  assign quot    = q_r[hcpg_pkg::U_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (ctl.init) begin
      cnt_r <= '0;
    end else if (ctl.step) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      num_r <= {dividend_idx, {hcpg_pkg::U_FRAC{1'b0}}};
      rem_r <= '0;
      q_r   <= '0;
    end else if (ctl.step) begin
      num_r <= {num_r[NW-2:0], 1'b0};
      rem_r <= fits ? IW'(trial - {1'b0, divisor}) : trial[IW-1:0];
      q_r   <= {q_r[NW-2:0], fits};
    end
  end

endmodule

@@ sv/hermite_curve_point_generator_unit.sv @@
// Cubic hermite curve tessellator. A request of N points (saturated to MAX_POINTS; zero gives
// no points) yields N transactions at u = floor(i*65536/(N-1)), the last one flagged. Each point
// is built in steps: one restoring-divider bit per cycle for u, then four passes per axis
// through a single shared multiplier evaluating the curve in horner form, then the point is
// handed over to the output register once the output can take it. The block takes no new
// request until the last point of the current one has been handed over.
// Depends on hcpg_pkg, hcpg_in_if, hcpg_out_if and hcpg_divider.

module hermite_curve_point_generator_unit #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 10
) (
  input  logic                             clk,
  input  logic                             rst_n,
  hcpg_in_if.sink                          in_chan,
  hcpg_out_if.source                       out_chan,
  input  logic                             cfg_we,
  input  logic [hcpg_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [COORD_BITS-1:0]            cfg_wdata
);

  localparam int K   = COORD_BITS;
  localparam int IW  = $clog2(MAX_POINTS);
  localparam int CW  = $clog2(MAX_POINTS + 1);
  localparam int DW  = K + 3;
  localparam int CCW = K + 4;
  localparam int HW  = K + 13;
  localparam int MW  = (K + 20 > 25) ? K + 20 : 25;
  localparam int PW  = MW + hcpg_pkg::U_W + 1;
  localparam int OW  = hcpg_pkg::OUT_W;

  function automatic logic signed [DW-1:0] cube_coef(
    input logic signed [K-1:0] p0, input logic signed [K-1:0] p1,
    input logic signed [K-1:0] t0, input logic signed [K-1:0] t1);
    return ((DW'(p0) - DW'(p1)) <<< 1) + DW'(t0) + DW'(t1);
  endfunction

  function automatic logic signed [CCW-1:0] square_coef(
    input logic signed [K-1:0] p0, input logic signed [K-1:0] p1,
    input logic signed [K-1:0] t0, input logic signed [K-1:0] t1);
    logic signed [CCW-1:0] dp;
    dp = CCW'(p1) - CCW'(p0);
    return dp + (dp <<< 1) - (CCW'(t0) <<< 1) - CCW'(t1);
  endfunction

  // configuration
  logic signed [K-1:0] cfg_r [hcpg_pkg::NUM_REGS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < hcpg_pkg::NUM_REGS; k++) begin
        cfg_r[k] <= K'(hcpg_pkg::REG_RESET[k]);
      end
    end else if (cfg_we) begin
      cfg_r[cfg_idx] <= cfg_wdata;
    end
  end

  // sequencer state
  logic                     busy_r, busy_nxt;
  logic [hcpg_pkg::PC_W-1:0] pc_r, pc_nxt;
  logic [IW-1:0]            point_index_r, point_index_nxt;
  logic [CW-1:0]            points_total_r;
  hcpg_pkg::ctrl_word_t     cw;

  // datapath
  logic signed [DW-1:0]     d_r [2];
  logic signed [CCW-1:0]    c_r [2];
  logic signed [MW-1:0]     acc_r;
  logic signed [HW-1:0]     hi_r;
  logic [hcpg_pkg::SPLIT_W-1:0] lo_r;
  logic [hcpg_pkg::T_W-1:0] t_r;
  logic signed [OW-1:0]     xr_r, yr_r;

  logic                     out_valid_r;
  logic signed [OW-1:0]     out_x_r, out_y_r;
  logic                     out_last_r;

  logic                     in_fire;
  logic [CW-1:0]            n_sat;
  logic                     last_pt;
  logic                     one_pt;
  logic                     can_emit;
  logic                     emit_fire;
  hcpg_pkg::div_ctl_t       div_ctl;
  logic [hcpg_pkg::U_W-1:0] div_quot;
  logic                     div_done;
  logic [hcpg_pkg::U_W-1:0] u_w;
  logic [IW-1:0]            dvs;

  logic signed [K-1:0]      a_w, b_w;
  logic signed [MW-1:0]     mul_a;
  logic signed [hcpg_pkg::U_W:0] mul_b;
  logic signed [PW-1:0]     prod;
  logic signed [PW-1:0]     sum_w;
  logic signed [PW-1:0]     q8_w;
  logic signed [OW-1:0]     sat_w;

  assign cw       = hcpg_pkg::ucode_rd(pc_r);
  assign in_fire  = in_chan.valid && in_chan.ready;
  assign n_sat    = (in_chan.point_count > hcpg_pkg::POINT_COUNT_W'(MAX_POINTS))
                    ? CW'(MAX_POINTS) : CW'(in_chan.point_count);
  assign last_pt  = (CW'(point_index_r) + CW'(1)) == points_total_r;
  assign one_pt   = points_total_r == CW'(1);
  assign can_emit = !out_valid_r || out_chan.ready;
  assign dvs      = IW'(points_total_r - CW'(1));
  assign u_w      = one_pt ? '0 : div_quot;

  assign in_chan.ready    = !busy_r;
  assign out_chan.valid   = out_valid_r;
  assign out_chan.x_pos   = out_x_r;
  assign out_chan.y_pos   = out_y_r;
  assign out_chan.is_last = out_last_r;

  hcpg_divider #(
    .IW (IW)
  ) u_div (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (div_ctl),
    .dividend_idx (point_index_r),
    .divisor      (dvs),
    .quot         (div_quot),
    .done         (div_done)
  );

  // next step
  always_comb begin
    busy_nxt        = busy_r;
    pc_nxt          = pc_r;
    point_index_nxt = point_index_r;
    if (!busy_r) begin
      pc_nxt          = hcpg_pkg::S_DIV_INIT;
      point_index_nxt = '0;
      if (in_fire && (n_sat != '0)) begin
        busy_nxt = 1'b1;
      end
    end else begin
      unique case (cw.jmp)
        hcpg_pkg::J_NEXT: begin
          pc_nxt = pc_r + hcpg_pkg::PC_W'(1);
        end
        hcpg_pkg::J_DIV_LOOP: begin
          pc_nxt = div_done ? pc_r + hcpg_pkg::PC_W'(1) : cw.tgt;
        end
        hcpg_pkg::J_EMIT: begin
          if (can_emit) begin
            if (last_pt) begin
              busy_nxt        = 1'b0;
              pc_nxt          = hcpg_pkg::S_DIV_INIT;
              point_index_nxt = '0;
            end else begin
              pc_nxt          = cw.tgt;
              point_index_nxt = point_index_r + IW'(1);
            end
          end
        end
        default: begin
          pc_nxt = hcpg_pkg::S_DIV_INIT;
        end
      endcase
    end
  end

  // step outputs
  always_comb begin
    div_ctl.init = busy_r && (cw.op == hcpg_pkg::OP_DIV_INIT);
    div_ctl.step = busy_r && (cw.op == hcpg_pkg::OP_DIV_STEP);
    emit_fire    = busy_r && (cw.op == hcpg_pkg::OP_EMIT) && can_emit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r        <= 1'b0;
      pc_r          <= hcpg_pkg::S_DIV_INIT;
      point_index_r <= '0;
      points_total_r <= '0;
    end else begin
      busy_r        <= busy_nxt;
      pc_r          <= pc_nxt;
      point_index_r <= point_index_nxt;
      if (in_fire) begin
        points_total_r <= n_sat;
      end
    end
  end

  // horner evaluation on the shared multiplier
  always_comb begin
    a_w = (cw.sel == hcpg_pkg::SEL_X) ? cfg_r[hcpg_pkg::REG_P0_X] : cfg_r[hcpg_pkg::REG_P0_Y];
    b_w = (cw.sel == hcpg_pkg::SEL_X) ? cfg_r[hcpg_pkg::REG_T0_X] : cfg_r[hcpg_pkg::REG_T0_Y];
    case (cw.op)
      hcpg_pkg::OP_H1: mul_a = MW'(d_r[cw.sel]);
      hcpg_pkg::OP_H2: mul_a = acc_r;
      hcpg_pkg::OP_LO: mul_a = MW'($signed({1'b0, lo_r}));
      hcpg_pkg::OP_HI: mul_a = MW'(hi_r);
      default:         mul_a = '0;
    endcase
  end

  assign mul_b = $signed({1'b0, u_w});
  assign prod  = mul_a * mul_b;

  always_comb begin
    case (cw.op)
      hcpg_pkg::OP_H1: sum_w = prod + (PW'(c_r[cw.sel]) <<< hcpg_pkg::U_FRAC);
      hcpg_pkg::OP_H2: sum_w = prod + (PW'(b_w) <<< (2 * hcpg_pkg::U_FRAC));
      hcpg_pkg::OP_HI: sum_w = prod + PW'($signed({1'b0, t_r}))
                               + (PW'(a_w) <<< hcpg_pkg::SPLIT_W);
      default:         sum_w = prod;
    endcase
    q8_w = sum_w >>> hcpg_pkg::U_FRAC;
    if (q8_w > PW'(hcpg_pkg::OUT_MAX)) begin
      sat_w = OW'(hcpg_pkg::OUT_MAX);
    end else if (q8_w < PW'(hcpg_pkg::OUT_MIN)) begin
      sat_w = OW'(hcpg_pkg::OUT_MIN);
    end else begin
      sat_w = OW'(q8_w);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      d_r[hcpg_pkg::SEL_X] <= cube_coef(cfg_r[hcpg_pkg::REG_P0_X], cfg_r[hcpg_pkg::REG_P1_X],
                                        cfg_r[hcpg_pkg::REG_T0_X], cfg_r[hcpg_pkg::REG_T1_X]);
      d_r[hcpg_pkg::SEL_Y] <= cube_coef(cfg_r[hcpg_pkg::REG_P0_Y], cfg_r[hcpg_pkg::REG_P1_Y],
                                        cfg_r[hcpg_pkg::REG_T0_Y], cfg_r[hcpg_pkg::REG_T1_Y]);
      c_r[hcpg_pkg::SEL_X] <= square_coef(cfg_r[hcpg_pkg::REG_P0_X], cfg_r[hcpg_pkg::REG_P1_X],
                                          cfg_r[hcpg_pkg::REG_T0_X], cfg_r[hcpg_pkg::REG_T1_X]);
      c_r[hcpg_pkg::SEL_Y] <= square_coef(cfg_r[hcpg_pkg::REG_P0_Y], cfg_r[hcpg_pkg::REG_P1_Y],
                                          cfg_r[hcpg_pkg::REG_T0_Y], cfg_r[hcpg_pkg::REG_T1_Y]);
    end
    if (busy_r) begin
      case (cw.op)
        hcpg_pkg::OP_H1: acc_r <= MW'(sum_w);
        hcpg_pkg::OP_H2: begin
          hi_r <= HW'(sum_w >>> hcpg_pkg::SPLIT_W);
          lo_r <= sum_w[hcpg_pkg::SPLIT_W-1:0];
        end
        hcpg_pkg::OP_LO: t_r <= prod[hcpg_pkg::SPLIT_W+hcpg_pkg::T_W-1:hcpg_pkg::SPLIT_W];
        hcpg_pkg::OP_HI: begin
          if (cw.sel == hcpg_pkg::SEL_X) begin
            xr_r <= sat_w;
          end else begin
            yr_r <= sat_w;
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_x_r    <= xr_r;
      out_y_r    <= yr_r;
      out_last_r <= last_pt;
    end
  end

`ifndef SYNTHESIS
  a_busy_counts: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (points_total_r != '0) && (CW'(point_index_r) < points_total_r))
    else $error("point index outside the request");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_fire && last_pt) |=> !busy_r && out_valid_r && out_last_r)
    else $error("request did not finish on its last point");

  a_last_u_one: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && (cw.op == hcpg_pkg::OP_H1) && last_pt && !one_pt) |-> (u_w == hcpg_pkg::U_ONE))
    else $error("last point not at u of one");
`endif

endmodule

@@ dv/testbench.sv @@
// testbench: self-checking bench for the hermite curve point generator, directed table then random
// requests, every point checked against a fixed-point predictor of the curve or a pinned end point
// depends on hcpg_pkg, hcpg_in_if, hcpg_out_if and hermite_curve_point_generator_unit

module testbench;

  localparam int COORD_W      = 10;
  localparam int MAX_PTS      = 64;
  localparam int RANDOM_REQS  = 500;
  localparam int SETTLE       = 40;
  localparam int LIMIT_CYCLES = 10000000;

  typedef struct {
    logic signed [hcpg_pkg::OUT_W-1:0] x_pos;
    logic signed [hcpg_pkg::OUT_W-1:0] y_pos;
    logic                              is_last;
  } curve_point_t;

  typedef enum {
    PRESET_KEEP,
    PRESET_MAX,
    PRESET_MIN,
    PRESET_CROSS,
    PRESET_FLIP,
    PRESET_ZERO
  } cfg_preset_t;

  typedef struct {
    cfg_preset_t preset;
    int          count;
    bit          pinned;
    int          x0;
    int          y0;
    int          x1;
    int          y1;
  } dir_row_t;

  // pinned rows carry the end points in q.8, interior points come from the predictor
  dir_row_t dir_rows [19] = '{
    '{PRESET_KEEP,   1, 1'b1,   -1280,       0,       0,       0},
    '{PRESET_KEEP,   2, 1'b1,   -1280,       0,    1280,       0},
    '{PRESET_KEEP,   0, 1'b0,       0,       0,       0,       0},
    '{PRESET_KEEP,   3, 1'b0,       0,       0,       0,       0},
    '{PRESET_KEEP,  64, 1'b1,   -1280,       0,    1280,       0},
    '{PRESET_KEEP,  65, 1'b1,   -1280,       0,    1280,       0},
    '{PRESET_KEEP, 127, 1'b1,   -1280,       0,    1280,       0},
    '{PRESET_KEEP,  85, 1'b0,       0,       0,       0,       0},
    '{PRESET_MAX,    2, 1'b1,  130816,  130816,  130816,  130816},
    '{PRESET_KEEP,  17, 1'b0,       0,       0,       0,       0},
    '{PRESET_MIN,    2, 1'b1, -131072, -131072, -131072, -131072},
    '{PRESET_KEEP,  42, 1'b0,       0,       0,       0,       0},
    '{PRESET_CROSS, 64, 1'b1,  130816, -131072,  130816, -131072},
    '{PRESET_KEEP,   1, 1'b1,  130816, -131072,       0,       0},
    '{PRESET_KEEP,   0, 1'b0,       0,       0,       0,       0},
    '{PRESET_FLIP,   2, 1'b1, -131072,  130816,  130816, -131072},
    '{PRESET_KEEP,  33, 1'b0,       0,       0,       0,       0},
    '{PRESET_ZERO,   5, 1'b1,       0,       0,       0,       0},
    '{PRESET_KEEP,   2, 1'b0,       0,       0,       0,       0}
  };

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           cfg_we;
  logic [hcpg_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [COORD_W-1:0]             cfg_wdata;

  hcpg_in_if  in_chan ();
  hcpg_out_if out_chan ();

  hermite_curve_point_generator_unit #(
    .MAX_POINTS (MAX_PTS),
    .COORD_BITS (COORD_W)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic signed [COORD_W-1:0] coord_regs [hcpg_pkg::NUM_REGS];
  curve_point_t              pending_points [$];
  int                        failures       = 0;
  int                        points_checked = 0;
  int                        requests_sent  = 0;
  int                        empty_requests = 0;
  int                        reg_writes     = 0;
  int                        cycle_count    = 0;

  function automatic logic signed [hcpg_pkg::OUT_W-1:0] clamp_q8(input longint v);
    if (v > hcpg_pkg::OUT_MAX) return hcpg_pkg::OUT_W'(hcpg_pkg::OUT_MAX);
    if (v < hcpg_pkg::OUT_MIN) return hcpg_pkg::OUT_W'(hcpg_pkg::OUT_MIN);
    return v[hcpg_pkg::OUT_W-1:0];
  endfunction

  function automatic longint coord(input hcpg_pkg::reg_idx_t r);
    return longint'(coord_regs[r]);
  endfunction

  // exact q.48 basis weights, sum floored to q.8
  function automatic curve_point_t predict_point(input int unsigned idx, input int unsigned n);
    curve_point_t pt;
    longint       u, u2, u3, c0, c1, c2, c3, sx, sy;
    u  = (n == 1) ? 0 : (longint'(idx) <<< hcpg_pkg::U_FRAC) / longint'(n - 1);
    u2 = u * u;
    u3 = u2 * u;
    c0 = 2 * u3 - 3 * (u2 <<< 16) + (longint'(1) <<< 48);
    c1 = 3 * (u2 <<< 16) - 2 * u3;
    c2 = u3 - 2 * (u2 <<< 16) + (u <<< 32);
    c3 = u3 - (u2 <<< 16);
    sx = c0 * coord(hcpg_pkg::REG_P0_X) + c1 * coord(hcpg_pkg::REG_P1_X)
       + c2 * coord(hcpg_pkg::REG_T0_X) + c3 * coord(hcpg_pkg::REG_T1_X);
    sy = c0 * coord(hcpg_pkg::REG_P0_Y) + c1 * coord(hcpg_pkg::REG_P1_Y)
       + c2 * coord(hcpg_pkg::REG_T0_Y) + c3 * coord(hcpg_pkg::REG_T1_Y);
    pt.x_pos   = clamp_q8(sx >>> 40);
    pt.y_pos   = clamp_q8(sy >>> 40);
    pt.is_last = (idx + 1 == n);
    return pt;
  endfunction

  task automatic note_failure(input string msg);
    failures++;
    if (failures <= 10) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  // offer one request and hold it until the transaction completes
  task automatic push_request(input int cnt, input bit pinned, input curve_point_t start_pt,
                              input curve_point_t end_pt);
    int           n;
    int           i;
    curve_point_t pt;
    in_chan.valid       <= 1'b1;
    in_chan.point_count <= cnt[hcpg_pkg::POINT_COUNT_W-1:0];
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    requests_sent++;
    n = (cnt > MAX_PTS) ? MAX_PTS : cnt;
    if (n == 0) empty_requests++;
    for (i = 0; i < n; i++) begin
      pt = predict_point(i, n);
      if (pinned && i == 0) begin
        pt.x_pos = start_pt.x_pos;
        pt.y_pos = start_pt.y_pos;
      end else if (pinned && i == n - 1) begin
        pt.x_pos = end_pt.x_pos;
        pt.y_pos = end_pt.y_pos;
      end
      pending_points.push_back(pt);
    end
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      in_chan.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // drain all points, then let the block settle
  task automatic wait_idle();
    in_chan.valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_coords(input int vals [hcpg_pkg::NUM_REGS]);
    int k;
    for (k = 0; k < hcpg_pkg::NUM_REGS; k++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= hcpg_pkg::reg_idx_t'(k);
      cfg_wdata <= vals[k][COORD_W-1:0];
      @(posedge clk);
      coord_regs[k] = vals[k][COORD_W-1:0];
      reg_writes++;
    end
    cfg_we <= 1'b0;
  endtask

  task automatic apply_preset(input cfg_preset_t p);
    int vals [hcpg_pkg::NUM_REGS];
    case (p)
      PRESET_MAX:   vals = '{511, 511, 511, 511, 511, 511, 511, 511};
      PRESET_MIN:   vals = '{-512, -512, -512, -512, -512, -512, -512, -512};
      PRESET_CROSS: vals = '{511, -512, 511, -512, 511, -512, -512, 511};
      PRESET_FLIP:  vals = '{-512, 511, 511, -512, -512, 511, 511, -512};
      default:      vals = '{0, 0, 0, 0, 0, 0, 0, 0};
    endcase
    write_coords(vals);
  endtask

  task automatic randomise_coords();
    int vals [hcpg_pkg::NUM_REGS];
    int k;
    for (k = 0; k < hcpg_pkg::NUM_REGS; k++) begin
      case ($urandom_range(0, 9))
        0:       vals[k] = 511;
        1:       vals[k] = -512;
        2:       vals[k] = 0;
        default: vals[k] = $urandom_range(0, 1023);
      endcase
    end
    write_coords(vals);
  endtask

  function automatic int pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 0;
    if (r < 10) return 2;
    if (r < 70) return $urandom_range(1, 12);
    if (r < 92) return $urandom_range(13, 64);
    return $urandom_range(65, 127);
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 4) == 0) return $urandom_range(20, 300);
    return $urandom_range(1, 6);
  endfunction

  // receiver back-pressure, its own pattern of modes
  int       stall_mode = 0;
  int       stall_left = 0;
  bit [3:0] rx_tick    = '0;

  always @(posedge clk) begin
    rx_tick <= rx_tick + 4'd1;
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 400);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_chan.ready <= 1'b1;
      1:       out_chan.ready <= ($urandom_range(0, 3) != 0);
      2:       out_chan.ready <= (rx_tick < 4'd11);
      default: out_chan.ready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  curve_point_t want;

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_points.size() == 0) begin
        note_failure($sformatf("point with nothing pending: x %0d y %0d last %0b",
                               out_chan.x_pos, out_chan.y_pos, out_chan.is_last));
      end else begin
        want = pending_points.pop_front();
        points_checked++;
        if (out_chan.x_pos !== want.x_pos || out_chan.y_pos !== want.y_pos ||
            out_chan.is_last !== want.is_last) begin
          note_failure($sformatf("x %0d/%0d y %0d/%0d last %0b/%0b (expected/actual)",
                                 want.x_pos, out_chan.x_pos, want.y_pos, out_chan.y_pos,
                                 want.is_last, out_chan.is_last));
        end
      end
    end
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d points still pending", cycle_count,
             pending_points.size());
    $display("** hermite_curve_point_generator_unit: FAILED **");
    $finish;
  end

  initial begin
    int           r;
    int           j;
    int           cnt;
    int           random_reqs;
    int           phase_len;
    int           burst_left;
    bit           no_gaps;
    curve_point_t start_pt;
    curve_point_t end_pt;

    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_idx             = '0;
    cfg_wdata           = '0;
    in_chan.valid       = 1'b0;
    in_chan.point_count = '0;
    out_chan.ready      = 1'b0;
    for (r = 0; r < hcpg_pkg::NUM_REGS; r++) coord_regs[r] = COORD_W'(hcpg_pkg::REG_RESET[r]);
    random_reqs = 0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (r = 0; r < $size(dir_rows); r++) begin
      if (dir_rows[r].preset != PRESET_KEEP) begin
        wait_idle();
        apply_preset(dir_rows[r].preset);
      end
      start_pt = '{dir_rows[r].x0[hcpg_pkg::OUT_W-1:0], dir_rows[r].y0[hcpg_pkg::OUT_W-1:0],
                   1'b0};
      end_pt   = '{dir_rows[r].x1[hcpg_pkg::OUT_W-1:0], dir_rows[r].y1[hcpg_pkg::OUT_W-1:0],
                   1'b1};
      push_request(dir_rows[r].count, dir_rows[r].pinned, start_pt, end_pt);
      idle_cycles($urandom_range(0, 3));
    end

    while (random_reqs < RANDOM_REQS) begin
      wait_idle();
      randomise_coords();
      phase_len  = $urandom_range(10, 60);
      no_gaps    = ($urandom_range(0, 3) == 0);
      burst_left = $urandom_range(1, 8);
      for (j = 0; j < phase_len && random_reqs < RANDOM_REQS; j++) begin
        cnt = pick_count();
        push_request(cnt, 1'b0, start_pt, end_pt);
        if (cnt != 0) random_reqs++;
        if ($urandom_range(0, 99) < 3) begin
          wait_idle();
        end else begin
          burst_left--;
          if (burst_left == 0) begin
            idle_cycles(no_gaps ? 0 : pick_gap());
            burst_left = $urandom_range(1, 8);
          end
        end
      end
    end

    in_chan.valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (2 * SETTLE) @(posedge clk);
    if (pending_points.size() != 0)
      note_failure($sformatf("%0d points never arrived", pending_points.size()));

    $display("covered %0d requests (%0d with no points) and %0d register writes",
             requests_sent, empty_requests, reg_writes);
    $display("checked %0d curve points, %0d mismatches", points_checked, failures);
    if (failures == 0) begin
      $display("** hermite_curve_point_generator_unit: PASSED **");
    end else begin
      $display("** hermite_curve_point_generator_unit: FAILED **");
    end
    $finish;
  end

endmodule
